[rtl/lzwc_pkg.sv]
// ----------------------------------------------------------------------------
// LZW compressor package
// Shared constants and the command and status bundles that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
package lzwc_pkg;

  // Default widest code the dictionary supports.
  localparam int DEF_MAX_CODE_BITS = 12;

  // Fixed field widths.
  localparam int CODE_W = 12;
  localparam int BYTE_W = 8;
  localparam int CFG_W  = 4;

  // Code space limits.
  localparam int FIRST_FREE   = 256;
  localparam int DEFAULT_BITS = 10;
  localparam int MIN_BITS     = 9;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(DEFAULT_BITS);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;        // Accept an input beat and start the lookup.
    logic probe_next;  // Step to the next hash slot.
    logic apply_hit;   // Extend the prefix with the matched code.
    logic apply_miss;  // Emit the prefix, insert the new string.
    logic flush;       // Emit the final prefix and restart the dictionary.
  } lzwc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ready;       // Hash table clearing after reset has finished.
    logic have_prefix;
    logic in_eom;      // End-of-message flag on the input port.
    logic eom;         // Latched end-of-message flag of the current byte.
    logic slot_hit;
    logic slot_free;
    logic room;        // Output queue can take two more codes.
  } lzwc_status_t;

endpackage

[rtl/lzwc_datapath.sv]
// ----------------------------------------------------------------------------
// LZW compressor datapath
// Holds the prefix, the hash table, the code-indexed dictionary, the code
// width register and the output queue. After reset the hash table is cleared
// slot by slot before input is taken.
// ----------------------------------------------------------------------------
module lzwc_datapath #(
  parameter int MAX_CODE_BITS = lzwc_pkg::DEF_MAX_CODE_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [lzwc_pkg::CFG_W-1:0]  cfg_data,
  input  logic [lzwc_pkg::BYTE_W-1:0] data_byte,
  input  logic                        end_of_message,
  input  lzwc_pkg::lzwc_cmd_t         cmd,
  output lzwc_pkg::lzwc_status_t      status,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [lzwc_pkg::CODE_W-1:0] code,
  output logic                        last_code
);
  import lzwc_pkg::*;

  localparam int PW     = MAX_CODE_BITS;
  localparam int NFW    = MAX_CODE_BITS + 1;
  localparam int KW     = MAX_CODE_BITS + BYTE_W;
  localparam int HB     = MAX_CODE_BITS + 1;
  localparam int HDEPTH = 1 << HB;
  localparam int DDEPTH = 1 << MAX_CODE_BITS;
  localparam int QW     = CODE_W + 1;

  // Architectural state.
  logic [CFG_W-1:0]  code_bits;
  logic [PW-1:0]     prefix;
  logic              have_prefix;
  logic [NFW-1:0]    next_free;
  logic [BYTE_W-1:0] byte_q;
  logic              eom_q;
  logic [HB-1:0]     addr;

  // Clearing pass over the hash table.
  logic [HB-1:0]     clr_addr;
  logic              clearing;

  // Memory read registers.
  logic [KW-1:0]     slot_key;
  logic [PW-1:0]     slot_code;
  logic [KW-1:0]     dict_q;

  logic [KW+PW-1:0]  hash_mem [HDEPTH];
  logic [KW-1:0]     dict_mem [DDEPTH];

  // Output queue.
  logic [QW-1:0]     queue [4];
  logic [1:0]        wr_ptr;
  logic [1:0]        rd_ptr;
  logic [2:0]        count;

  logic [KW-1:0]     key;
  logic [KW-1:0]     key_in;
  logic [4:0]        eff_bits;
  logic [NFW-1:0]    limit;
  logic              can_add;
  logic              slot_valid;
  logic              push;
  logic [QW-1:0]     push_data;
  logic              pop;

  // Fold a (prefix, byte) key into a hash slot index.
  function automatic logic [HB-1:0] hash_key(input logic [KW-1:0] k);
    logic [HB-1:0] h;
    h = k[HB-1:0] ^ HB'(k[KW-1:HB]);
    return h;
  endfunction

  assign key    = {prefix, byte_q};
  assign key_in = {prefix, data_byte};

  // Effective code width and the resulting dictionary limit.
  always_comb begin
    if (code_bits < CFG_W'(MIN_BITS)) begin
      eff_bits = 5'(DEFAULT_BITS);
    end else if ({1'b0, code_bits} > 5'(MAX_CODE_BITS)) begin
      eff_bits = 5'(MAX_CODE_BITS);
    end else begin
      eff_bits = {1'b0, code_bits};
    end
  end

  assign limit   = (NFW'(1) << eff_bits) - NFW'(1);
  assign can_add = next_free < limit;

  // A slot counts only if its code was assigned in this message to that key.
  assign slot_valid = (slot_code >= PW'(FIRST_FREE)) && ({1'b0, slot_code} < next_free) &&
                      (dict_q == slot_key);

  assign status.ready       = !clearing;
  assign status.have_prefix = have_prefix;
  assign status.in_eom      = end_of_message;
  assign status.eom         = eom_q;
  assign status.slot_hit    = slot_valid && (slot_key == key);
  assign status.slot_free   = !slot_valid;
  assign status.room        = count <= 3'd2;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      code_bits <= CFG_RESET;
    end else if (cfg_write) begin
      code_bits <= cfg_data;
    end
  end

  // Clearing pass: one hash slot per cycle after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      clearing <= 1'b1;
    end else if (clearing) begin
      clr_addr <= clr_addr + HB'(1);
      if (&clr_addr) begin
        clearing <= 1'b0;
      end
    end
  end

  // Prefix, dictionary fill and probe address.
  always_ff @(posedge clk) begin
    if (rst) begin
      prefix      <= '0;
      have_prefix <= 1'b0;
      next_free   <= NFW'(FIRST_FREE);
    end else begin
      if (cmd.take) begin
        byte_q <= data_byte;
        eom_q  <= end_of_message;
        addr   <= hash_key(key_in);
        if (!have_prefix) begin
          prefix      <= PW'(data_byte);
          have_prefix <= 1'b1;
        end
      end
      if (cmd.probe_next) begin
        addr <= addr + HB'(1);
      end
      if (cmd.apply_hit) begin
        prefix <= slot_code;
      end
      if (cmd.apply_miss) begin
        prefix <= PW'(byte_q);
        if (can_add) begin
          next_free <= next_free + NFW'(1);
        end
      end
      if (cmd.flush) begin
        prefix      <= '0;
        have_prefix <= 1'b0;
        next_free   <= NFW'(FIRST_FREE);
      end
    end
  end

  // Hash table: registered read of the probed slot, clear or insert on a miss.
  always_ff @(posedge clk) begin
    {slot_key, slot_code} <= hash_mem[addr];
    if (clearing) begin
      hash_mem[clr_addr] <= '0;
    end else if (cmd.apply_miss && can_add) begin
      hash_mem[addr] <= {key, next_free[PW-1:0]};
    end
  end

  // Code-indexed dictionary used to confirm a slot belongs to this message.
  always_ff @(posedge clk) begin
    dict_q <= dict_mem[slot_code];
    if (cmd.apply_miss && can_add) begin
      dict_mem[next_free[PW-1:0]] <= key;
    end
  end

  // Output queue push and pop.
  assign push      = cmd.apply_miss || cmd.flush;
  assign push_data = {CODE_W'(prefix), cmd.flush};
  assign out_valid = count != 3'd0;
  assign pop       = out_valid && !out_stall;
  assign {code, last_code} = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 2'd1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + 3'(push) - 3'(pop);
    end
  end

endmodule

[rtl/lzwc_ctrl.sv]
// ----------------------------------------------------------------------------
// LZW compressor controller
// Sequences accept, hash probes, the hit or miss update and the final flush.
// ----------------------------------------------------------------------------
module lzwc_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  lzwc_pkg::lzwc_status_t status,
  output lzwc_pkg::lzwc_cmd_t    cmd
);
  import lzwc_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_RD_SLOT = 3'd1;
  localparam logic [2:0] S_RD_DICT = 3'd2;
  localparam logic [2:0] S_CHECK   = 3'd3;
  localparam logic [2:0] S_FLUSH   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;

  assign in_stall = !((state == S_IDLE) && status.room && status.ready);
  assign accept   = in_valid && !in_stall;

  // Next state and commands.
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.take = 1'b1;
          if (status.have_prefix) begin
            state_next = S_RD_SLOT;
          end else if (status.in_eom) begin
            state_next = S_FLUSH;
          end
        end
      end
      S_RD_SLOT: begin
        state_next = S_RD_DICT;
      end
      S_RD_DICT: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        priority if (status.slot_hit) begin
          cmd.apply_hit = 1'b1;
          state_next    = status.eom ? S_FLUSH : S_IDLE;
        end else if (status.slot_free) begin
          cmd.apply_miss = 1'b1;
          state_next     = status.eom ? S_FLUSH : S_IDLE;
        end else begin
          cmd.probe_next = 1'b1;
          state_next     = S_RD_SLOT;
        end
      end
      S_FLUSH: begin
        cmd.flush  = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/lzw_byte_compressor.sv]
// ----------------------------------------------------------------------------
// LZW byte compressor
// Streaming LZW compressor with fixed-width codes and a hashed dictionary.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Payload
//  cfg       in         cfg_write            cfg_data (code_bits)
//  in        in         in_valid, in_stall   data_byte, end_of_message
//  out       out        out_valid, out_stall code, last_code
//
// A byte that starts a message needs no probe; other bytes take one or more
// hash probes, each through slot read, dictionary read and check states; a
// final byte adds a flush state. Each probe reads the hash table, then the
// dictionary. Synchronous reset starts a pass that clears all hash slots,
// 2^(MAX_CODE_BITS+1) (8192 by default), one a cycle, with input stalled.
// Input is taken while up to two codes wait in the four-beat output queue.
// ----------------------------------------------------------------------------
module lzw_byte_compressor #(
  parameter int MAX_CODE_BITS = lzwc_pkg::DEF_MAX_CODE_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [lzwc_pkg::CFG_W-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [lzwc_pkg::BYTE_W-1:0] data_byte,
  input  logic                        end_of_message,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [lzwc_pkg::CODE_W-1:0] code,
  output logic                        last_code
);
  import lzwc_pkg::*;

  lzwc_cmd_t    cmd;
  lzwc_status_t status;

  // Controller.
  lzwc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath.
  lzwc_datapath #(
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .data_byte      (data_byte),
    .end_of_message (end_of_message),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .code           (code),
    .last_code      (last_code)
  );

endmodule

[rtl/lzwc_checker.sv]
// ----------------------------------------------------------------------------
// LZW compressor port checker
// Watches the top-level ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
module lzwc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        end_of_message,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [lzwc_pkg::CODE_W-1:0] code,
  input logic                        last_code
);

  // A stalled output beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(code) && $stable(last_code))
    else $error("output beat changed while stalled");

  // Nothing is offered right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // A final byte always leaves work behind, so input stalls next cycle.
  a_eom_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && end_of_message |=> in_stall)
    else $error("input taken right after a final byte");

endmodule

bind lzw_byte_compressor lzwc_checker u_lzwc_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .end_of_message (end_of_message),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .code           (code),
  .last_code      (last_code)
);
